>>> sv/iorr_pkg.sv
`timescale 1ns / 1ps

package iorr_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SEQ_W  = 32;
	localparam int PAY_W  = 32;
	localparam int MEM_W  = SEQ_W + PAY_W;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [SEQ_W-1:0]  seq_t;
	typedef logic [PAY_W-1:0]  pay_t;

	typedef struct packed {
		logic              we;
		slot_t             waddr;
		logic [MEM_W-1:0]  wdata;
		logic              re;
		slot_t             raddr;
	} ram_req_t;

	typedef struct packed {
		logic  valid;
		seq_t  seq;
		pay_t  payload;
		logic  last;
	} push_t;

endpackage

>>> sv/iorr_in_if.sv
`timescale 1ns / 1ps

interface iorr_in_if;
	logic                 valid;
	logic                 ready;
	logic [iorr_pkg::SEQ_W-1:0] seq_number;
	logic [iorr_pkg::PAY_W-1:0] payload_word;

	modport source (output valid, output seq_number, output payload_word, input ready);
	modport sink   (input valid, input seq_number, input payload_word, output ready);
endinterface

>>> sv/iorr_out_if.sv
`timescale 1ns / 1ps

interface iorr_out_if;
	logic                 valid;
	logic                 ready;
	logic [iorr_pkg::SEQ_W-1:0] out_seq;
	logic [iorr_pkg::PAY_W-1:0] out_payload;
	logic                 last_of_run;

	modport source (output valid, output out_seq, output out_payload, output last_of_run,
		input ready);
	modport sink   (input valid, input out_seq, input out_payload, input last_of_run,
		output ready);
endinterface

>>> sv/iorr_ram.sv
`timescale 1ns / 1ps

module iorr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/iorr_ctrl.sv
`timescale 1ns / 1ps

module iorr_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sink_connected,
	iorr_in_if.sink                                rsp_in,
	output iorr_pkg::ram_req_t                     ram_req,
	input  logic [iorr_pkg::MEM_W-1:0]             ram_rdata,
	input  logic                                   out_free,
	output iorr_pkg::push_t                        push
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_LOOK,
		S_CHECK,
		S_FLUSH
	} state_t;

	localparam logic [iorr_pkg::SLOT_W:0] SLOTS_X = (iorr_pkg::SLOT_W+1)'(iorr_pkg::SLOTS);
	localparam iorr_pkg::slot_t LAST_SLOT = iorr_pkg::SLOT_W'(iorr_pkg::SLOTS - 1);

	state_t               state_q;
	iorr_pkg::seq_t       ne_q;
	iorr_pkg::slot_t      ns_q;
	logic                 valid_q [iorr_pkg::SLOTS];
	iorr_pkg::seq_t       seq_q;
	iorr_pkg::pay_t       pay_q;
	logic                 pend_v_q;
	iorr_pkg::seq_t       pend_seq_q;
	iorr_pkg::pay_t       pend_pay_q;

	iorr_pkg::seq_t               seq_off;
	logic                         in_win;
	logic                         wrapped;
	logic [iorr_pkg::SLOT_W:0]    sum;
	iorr_pkg::slot_t              slot;
	logic                         accept_ok;
	logic                         hit;
	logic                         take;
	iorr_pkg::slot_t              ns_next;

	assign rsp_in.ready = (state_q == S_IDLE);

	always_comb begin
		seq_off = seq_q - ne_q;
		in_win  = seq_off < iorr_pkg::SEQ_W'(iorr_pkg::SLOTS);
		wrapped = seq_q < ne_q;
		sum     = {1'b0, ns_q} + {1'b0, seq_off[iorr_pkg::SLOT_W-1:0]};
		if (wrapped) begin
			slot = seq_q[iorr_pkg::SLOT_W-1:0];
		end else if (sum >= SLOTS_X) begin
			slot = iorr_pkg::SLOT_W'(sum - SLOTS_X);
		end else begin
			slot = sum[iorr_pkg::SLOT_W-1:0];
		end
		accept_ok = sink_connected && in_win && !valid_q[slot];
		hit       = ram_rdata[iorr_pkg::MEM_W-1:iorr_pkg::PAY_W] == ne_q;
		take      = (state_q == S_CHECK) && hit && (!pend_v_q || out_free);
		if (ne_q == '1 || ns_q == LAST_SLOT) begin
			ns_next = '0;
		end else begin
			ns_next = ns_q + 1'b1;
		end
	end

	always_comb begin
		ram_req.we    = (state_q == S_INSERT) && accept_ok;
		ram_req.waddr = slot;
		ram_req.wdata = {seq_q, pay_q};
		ram_req.re    = (state_q == S_LOOK) && valid_q[ns_q];
		ram_req.raddr = ns_q;

		push.seq     = pend_seq_q;
		push.payload = pend_pay_q;
		push.last    = (state_q == S_FLUSH);
		push.valid   = pend_v_q && out_free &&
			((state_q == S_FLUSH) || ((state_q == S_CHECK) && hit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ne_q     <= '0;
			ns_q     <= '0;
			pend_v_q <= 1'b0;
			for (int i = 0; i < iorr_pkg::SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rsp_in.valid) begin
						seq_q   <= rsp_in.seq_number;
						pay_q   <= rsp_in.payload_word;
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					if (accept_ok) begin
						valid_q[slot] <= 1'b1;
						state_q       <= S_LOOK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LOOK: begin
					state_q <= valid_q[ns_q] ? S_CHECK : S_FLUSH;
				end
				S_CHECK: begin
					if (!hit) begin
						state_q <= S_FLUSH;
					end else if (take) begin
						pend_v_q      <= 1'b1;
						pend_seq_q    <= ne_q;
						pend_pay_q    <= ram_rdata[iorr_pkg::PAY_W-1:0];
						valid_q[ns_q] <= 1'b0;
						ne_q          <= ne_q + 1'b1;
						ns_q          <= ns_next;
						state_q       <= S_LOOK;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("ram read and write in the same cycle");

	a_release_advances: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ne_q == $past(ne_q) + 1'b1)
		else $error("release did not advance next expected");

	a_push_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> pend_v_q && out_free)
		else $error("push without pending word");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending word left behind at end of run");

endmodule

>>> sv/in_order_response_release.sv
// An arrival that completes a run is written to the slot memory, read back, checked, held in a
// pending register and then moved to the output register. Arrivals are taken only when idle, after
//   the previous one is stored and its run is closed by the read-check loop over the single read port.
// The word being handed out waits in an output register; the run continues behind it into a pending register.
// Reset (arst_n low): sink connected, next expected 0, all slots empty; no clearing pass.
`timescale 1ns / 1ps

module in_order_response_release (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	iorr_in_if.sink     rsp_in,
	iorr_out_if.source  rel_out
);

	logic                            sink_connected_q;
	iorr_pkg::ram_req_t              ram_req;
	logic [iorr_pkg::MEM_W-1:0]      ram_rdata;
	iorr_pkg::push_t                 push;
	logic                            out_free;
	logic                            out_v_q;
	iorr_pkg::seq_t                  out_seq_q;
	iorr_pkg::pay_t                  out_pay_q;
	logic                            out_last_q;

	assign out_free = !out_v_q || rel_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_connected_q <= 1'b1;
		end else if (cfg_we) begin
			sink_connected_q <= cfg_wdata;
		end
	end

	iorr_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.sink_connected (sink_connected_q),
		.rsp_in         (rsp_in),
		.ram_req        (ram_req),
		.ram_rdata      (ram_rdata),
		.out_free       (out_free),
		.push           (push)
	);

	iorr_ram #(
		.WIDTH (iorr_pkg::MEM_W),
		.DEPTH (iorr_pkg::SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push.valid) begin
			out_v_q <= 1'b1;
		end else if (rel_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_seq_q  <= push.seq;
			out_pay_q  <= push.payload;
			out_last_q <= push.last;
		end
	end

	assign rel_out.valid       = out_v_q;
	assign rel_out.out_seq     = out_seq_q;
	assign rel_out.out_payload = out_pay_q;
	assign rel_out.last_of_run = out_last_q;

endmodule
